// ===== design/pcrst_pkg.sv =====
// ----------------------------------------------------------------------------
// pcrst_pkg
// Shared types and constants of the per-requester request slot table.
// ----------------------------------------------------------------------------
package pcrst_pkg;

   localparam int PCRST_CPUS  = 16;
   localparam int PCRST_SLOTS = 8;

   localparam int OPCODE_W  = 2;
   localparam int CPU_W     = 4;
   localparam int SLOT_W    = 3;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 16;

   typedef enum logic [OPCODE_W-1:0] {
      OP_QUERY   = 2'd0,
      OP_PUBLISH = 2'd1,
      OP_POP     = 2'd2,
      OP_NOP     = 2'd3
   } opcode_type;

   typedef enum logic {
      ST_IDLE   = 1'b0,
      ST_LOOKUP = 1'b1
   } state_type;

endpackage

// ===== design/per_cpu_request_slot_table.sv =====
// ----------------------------------------------------------------------------
// per_cpu_request_slot_table
// Per-requester ring of request slots with publish, query and pop.
// ----------------------------------------------------------------------------
// Items arrive on the req_ channel (opcode and requester) and each one gives
// exactly one item on the rsp_ channel. A query reports the requester's next
// slot and whether it is still pending. A publish marks that slot pending
// and advances the ring, or is refused with busy set when the slot is still
// pending. A pop returns and clears the pending request with the lowest
// requester number, then the lowest slot.
// Each item passes through two steps: the acceptance step reads the
// requester's entry from the slot memories, the lookup step modifies it,
// writes it back and loads the response register. Due to the memory read
// latency of this read-modify-write, no item is taken during lookup.
// A response waiting in the output register does not block acceptance of
// the next item; if the receiver stalls, the following item holds in the
// lookup step until the response register frees up.
// After reset all masks and indexes read as zero through per-entry valid
// bits, and the block accepts items as soon as reset is released.
// ----------------------------------------------------------------------------
module per_cpu_request_slot_table
   import pcrst_pkg::*;
#(
   parameter int CPUS  = PCRST_CPUS,
   parameter int SLOTS = PCRST_SLOTS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [1:0] opcode, [5:2] cpu, [7:6] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [2:0] slot, [6:3] cpu_out, [7] busy_res, [8] found, [15:9] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int CPU_AW  = (CPUS > 1) ? $clog2(CPUS) : 1;
   localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   state_type          state_ff, state_in;
   opcode_type         op_ff, op_in;
   logic [CPU_W-1:0]   cpu_ff, cpu_in;
   logic [CPU_AW-1:0]  addr_ff, addr_in;
   logic               hit_ff, hit_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic [CPU_W-1:0]   rsp_cpu_ff, rsp_cpu_in;
   logic               rsp_busy_ff, rsp_busy_in;
   logic               rsp_found_ff, rsp_found_in;

   logic                   accept;
   logic                   finish;
   opcode_type             req_op;
   logic [CPU_W-1:0]       req_cpu;
   logic [CPU_AW+CPU_W-1:0] req_cpu_ext;
   logic                   req_in_range;
   logic [CPU_AW-1:0]      pop_addr;
   logic                   pop_any;

   logic [SLOTS-1:0]       rd_mask;
   logic [SLOT_AW-1:0]     rd_next;
   logic [CPUS-1:0]        nonempty;
   logic                   wr_en;
   logic [SLOTS-1:0]       wr_mask;
   logic [SLOT_AW-1:0]     wr_next;

   logic [SLOT_AW-1:0]     pop_slot;
   logic                   busy;
   logic [SLOT_AW+SLOT_W-1:0] next_ext;
   logic [SLOT_AW+SLOT_W-1:0] pop_slot_ext;
   logic [CPU_AW+CPU_W-1:0]   addr_ext;

   assign req_op       = opcode_type'(req_tdata[OPCODE_W-1:0]);
   assign req_cpu      = req_tdata[OPCODE_W+CPU_W-1:OPCODE_W];
   assign req_cpu_ext  = {{CPU_AW{1'b0}}, req_cpu};
   assign req_in_range = req_cpu_ext < (CPU_AW+CPU_W)'(CPUS);

   always_comb begin
      pop_addr = '0;
      pop_any  = |nonempty;
      for (int i = CPUS - 1; i >= 0; i--) begin
         if (nonempty[i]) begin
            pop_addr = CPU_AW'(i);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      finish     = 1'b0;
      case (state_ff)
         ST_IDLE:   req_tready = 1'b1;
         ST_LOOKUP: finish     = !rsp_valid_ff || rsp_tready;
         default: begin
            req_tready = 1'b0;
            finish     = 1'b0;
         end
      endcase
   end

   assign accept = req_tvalid && req_tready;

   always_comb begin
      op_in   = op_ff;
      cpu_in  = cpu_ff;
      addr_in = addr_ff;
      hit_in  = hit_ff;
      if (accept) begin
         op_in  = req_op;
         cpu_in = req_cpu;
         if (req_op == OP_POP) begin
            addr_in = pop_addr;
            hit_in  = pop_any;
         end else begin
            addr_in = req_cpu_ext[CPU_AW-1:0];
            hit_in  = req_in_range;
         end
      end
   end

   pcrst_slot_store #(
      .CPUS    (CPUS),
      .SLOTS   (SLOTS),
      .CPU_AW  (CPU_AW),
      .SLOT_AW (SLOT_AW)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_addr  (addr_in),
      .rd_mask  (rd_mask),
      .rd_next  (rd_next),
      .wr_en    (wr_en),
      .wr_addr  (addr_ff),
      .wr_mask  (wr_mask),
      .wr_next  (wr_next),
      .nonempty (nonempty)
   );

   always_comb begin
      pop_slot = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (rd_mask[i]) begin
            pop_slot = SLOT_AW'(i);
         end
      end
   end

   assign busy         = rd_mask[rd_next];
   assign next_ext     = {{SLOT_W{1'b0}}, rd_next};
   assign pop_slot_ext = {{SLOT_W{1'b0}}, pop_slot};
   assign addr_ext     = {{CPU_W{1'b0}}, addr_ff};

   always_comb begin
      wr_en        = 1'b0;
      wr_mask      = rd_mask;
      wr_next      = rd_next;
      rsp_slot_in  = '0;
      rsp_cpu_in   = cpu_ff;
      rsp_busy_in  = 1'b0;
      rsp_found_in = 1'b0;
      case (op_ff)
         OP_QUERY, OP_PUBLISH: begin
            if (hit_ff) begin
               rsp_slot_in = next_ext[SLOT_W-1:0];
               rsp_busy_in = busy;
               if (op_ff == OP_PUBLISH && !busy) begin
                  wr_en   = finish;
                  wr_mask = rd_mask | (SLOTS'(1) << rd_next);
                  wr_next = (rd_next == SLOT_AW'(SLOTS - 1)) ? '0 : rd_next + SLOT_AW'(1);
               end
            end
         end
         OP_POP: begin
            rsp_cpu_in = '0;
            if (hit_ff) begin
               wr_en        = finish;
               wr_mask      = rd_mask & ~(SLOTS'(1) << pop_slot);
               rsp_slot_in  = pop_slot_ext[SLOT_W-1:0];
               rsp_cpu_in   = addr_ext[CPU_W-1:0];
               rsp_found_in = 1'b1;
            end
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      cpu_ff  <= cpu_in;
      addr_ff <= addr_in;
      hit_ff  <= hit_in;
      if (finish) begin
         rsp_slot_ff  <= rsp_slot_in;
         rsp_cpu_ff   <= rsp_cpu_in;
         rsp_busy_ff  <= rsp_busy_in;
         rsp_found_ff <= rsp_found_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_found_ff, rsp_busy_ff, rsp_cpu_ff, rsp_slot_ff};

endmodule

// ===== design/pcrst_slot_store.sv =====
// ----------------------------------------------------------------------------
// pcrst_slot_store
// Holds the pending masks and next-slot indexes of all requesters in two
// synchronous memories, with per-entry valid bits and a per-requester
// summary of which requesters have anything pending.
// ----------------------------------------------------------------------------
module pcrst_slot_store
   import pcrst_pkg::*;
#(
   parameter int CPUS    = PCRST_CPUS,
   parameter int SLOTS   = PCRST_SLOTS,
   parameter int CPU_AW  = (CPUS > 1) ? $clog2(CPUS) : 1,
   parameter int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               rd_en,
   input  logic [CPU_AW-1:0]  rd_addr,
   output logic [SLOTS-1:0]   rd_mask,
   output logic [SLOT_AW-1:0] rd_next,
   input  logic               wr_en,
   input  logic [CPU_AW-1:0]  wr_addr,
   input  logic [SLOTS-1:0]   wr_mask,
   input  logic [SLOT_AW-1:0] wr_next,
   output logic [CPUS-1:0]    nonempty
);

   logic [SLOTS-1:0]   mask_mem [CPUS];
   logic [SLOT_AW-1:0] next_mem [CPUS];
   logic [SLOTS-1:0]   mask_q_ff;
   logic [SLOT_AW-1:0] next_q_ff;
   logic               valid_q_ff;
   logic [CPUS-1:0]    valid_ff;
   logic [CPUS-1:0]    nonempty_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mask_mem[wr_addr] <= wr_mask;
         next_mem[wr_addr] <= wr_next;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         mask_q_ff  <= mask_mem[rd_addr];
         next_q_ff  <= next_mem[rd_addr];
         valid_q_ff <= valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         nonempty_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr]    <= 1'b1;
         nonempty_ff[wr_addr] <= |wr_mask;
      end
   end

   // An entry never written since reset reads as all zero.
   assign rd_mask  = valid_q_ff ? mask_q_ff : '0;
   assign rd_next  = valid_q_ff ? next_q_ff : '0;
   assign nonempty = nonempty_ff;

endmodule

// ===== bench/per_cpu_request_slot_table_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// per_cpu_request_slot_table_tb
// Self-checking bench for the per-requester request slot table.
// ----------------------------------------------------------------------------
// A short directed part covers the empty table, a full ring with a refused
// publish, pop priority and the unused opcode. Random bursts of queries,
// publishes and pops follow, in fill and drain mixes over wide and narrow
// requester sets. A long output stall then makes the block back up. Each
// response is checked against an in-bench model of the masks and ring indexes.
// ----------------------------------------------------------------------------
module per_cpu_request_slot_table_tb;
   import pcrst_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic [CPU_W-1:0]  owner;
      logic              busy;
      logic              found;
   } slot_response_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   logic [PCRST_SLOTS-1:0] pending_slots [PCRST_CPUS];
   logic [SLOT_W-1:0]      ring_index [PCRST_CPUS];
   slot_response_type      expected_responses [$];

   bit idle_en = 1'b1;
   bit sink_hold = 1'b0;
   int sink_wait = 0;
   int cycle_count = 0;
   int mismatches = 0;
   int items_sent = 0;
   int refused_publishes = 0;
   int popped_requests = 0;
   int empty_pops = 0;

   per_cpu_request_slot_table uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
         $display("[per_cpu_request_slot_table] ERROR");
         $finish;
      end
   end

   function automatic slot_response_type predict_slot_table(opcode_type op,
                                                            logic [CPU_W-1:0] cpu);
      slot_response_type r;
      logic [SLOT_W-1:0] s;
      r = '{slot: '0, owner: cpu, busy: 1'b0, found: 1'b0};
      case (op)
         OP_QUERY, OP_PUBLISH: begin
            if (int'(cpu) < PCRST_CPUS) begin
               s = ring_index[cpu];
               r.slot = s;
               r.busy = pending_slots[cpu][s];
               if (op == OP_PUBLISH && r.busy)
                  refused_publishes++;
               if (op == OP_PUBLISH && !r.busy) begin
                  pending_slots[cpu][s] = 1'b1;
                  ring_index[cpu] = SLOT_W'((int'(s) + 1) % PCRST_SLOTS);
               end
            end
         end
         OP_POP: begin
            r.owner = '0;
            for (int c = 0; c < PCRST_CPUS && !r.found; c++) begin
               for (int k = 0; k < PCRST_SLOTS && !r.found; k++) begin
                  if (pending_slots[c][k]) begin
                     pending_slots[c][k] = 1'b0;
                     r.slot = SLOT_W'(k);
                     r.owner = CPU_W'(c);
                     r.found = 1'b1;
                  end
               end
            end
            if (r.found)
               popped_requests++;
            else
               empty_pops++;
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   task automatic compare_field(string label, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
         mismatches++;
      end
   endtask

   task automatic check_slot_response(logic [RSP_DATA_W-1:0] data);
      slot_response_type want;
      if (expected_responses.size() == 0) begin
         $display("%0t: unexpected response, expected none, actual %h", $time, data);
         mismatches++;
         return;
      end
      want = expected_responses.pop_front();
      compare_field("slot", int'(want.slot), int'(data[2:0]));
      compare_field("cpu_out", int'(want.owner), int'(data[6:3]));
      compare_field("busy_res", int'(want.busy), int'(data[7]));
      compare_field("found", int'(want.found), int'(data[8]));
      compare_field("padding", 0, int'(data[15:9]));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         sink_wait = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_slot_response(rsp_tdata);
            sink_wait = idle_en ? $urandom_range(0, 9) : 0;
         end else if (sink_wait > 0) begin
            sink_wait--;
         end
         rsp_tready <= !sink_hold && sink_wait == 0;
      end
   end

   task automatic send_item(opcode_type op, logic [CPU_W-1:0] cpu);
      int gap;
      gap = idle_en ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, cpu, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_responses.push_back(predict_slot_table(op, cpu));
      items_sent++;
   endtask

   task automatic hold_responses(int cycles);
      sink_hold <= 1'b1;
      repeat (cycles) @(posedge clock);
      sink_hold <= 1'b0;
   endtask

   function automatic opcode_type pick_opcode(int publish_pct, int pop_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < publish_pct) return OP_PUBLISH;
      if (roll < publish_pct + pop_pct) return OP_POP;
      if (roll < 95) return OP_QUERY;
      return OP_NOP;
   endfunction

   task automatic test_empty_table();
      send_item(OP_POP, 4'd9);
      send_item(OP_QUERY, 4'd0);
      send_item(OP_QUERY, 4'd15);
   endtask

   task automatic test_ring_wrap_and_refusal();
      repeat (PCRST_SLOTS) send_item(OP_PUBLISH, 4'd15);
      send_item(OP_PUBLISH, 4'd15);
      send_item(OP_QUERY, 4'd15);
   endtask

   task automatic test_pop_priority();
      send_item(OP_PUBLISH, 4'd0);
      repeat (3) send_item(OP_POP, 4'd7);
      send_item(OP_PUBLISH, 4'd15);
      send_item(OP_QUERY, 4'd15);
   endtask

   task automatic test_unused_opcode();
      send_item(OP_NOP, 4'd10);
   endtask

   task automatic test_random_traffic();
      int mode;
      bit narrow;
      logic [CPU_W-1:0] base;
      logic [CPU_W-1:0] cpu;
      for (int burst = 0; burst < 29; burst++) begin
         mode = $urandom_range(0, 2);
         narrow = $urandom_range(0, 1);
         base = CPU_W'($urandom_range(0, 15));
         idle_en = $urandom_range(0, 3) != 0;
         repeat (50) begin
            cpu = narrow ? base + CPU_W'($urandom_range(0, 2)) : CPU_W'($urandom_range(0, 15));
            case (mode)
               0: send_item(pick_opcode(55, 25), cpu);
               1: send_item(pick_opcode(20, 60), cpu);
               default: send_item(pick_opcode(40, 40), cpu);
            endcase
         end
      end
      idle_en = 1'b1;
   endtask

   task automatic test_output_stall();
      idle_en = 1'b0;
      fork
         hold_responses(250);
         repeat (40) send_item(pick_opcode(45, 45), CPU_W'($urandom_range(0, 15)));
      join
      idle_en = 1'b1;
   endtask

   initial begin
      for (int c = 0; c < PCRST_CPUS; c++) begin
         pending_slots[c] = '0;
         ring_index[c] = '0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_table();
      test_ring_wrap_and_refusal();
      test_pop_priority();
      test_unused_opcode();
      test_random_traffic();
      test_output_stall();

      req_tvalid <= 1'b0;
      while (expected_responses.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d items with random gaps, output stalls and one long hold-off.",
               items_sent);
      $display("Saw %0d refused publishes, %0d pops that found a request, %0d empty pops.",
               refused_publishes, popped_requests, empty_pops);
      if (mismatches == 0) begin
         $display("[per_cpu_request_slot_table] OK");
      end else begin
         $display("[per_cpu_request_slot_table] ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/pcrst_pkg.sv
design/pcrst_slot_store.sv
design/per_cpu_request_slot_table.sv
bench/per_cpu_request_slot_table_tb.sv
